// ----- hdl/p1305_pkg.sv -----
// Shared constants for the Poly1305 MAC block.
package p1305_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int MSG_W       = 8 * BLOCK_BYTES + 1;  // block plus the pad bit of the appended 0x01 byte
    localparam int ACC_W       = 130;                  // fully reduced accumulator
    localparam int H_W         = 131;                  // acc + block, before multiply
    localparam int PROD_W      = 131;                  // partial product, kept below 2^130 + 15
    localparam int MUL_STEPS   = H_W;                  // one multiplier bit per cycle
    localparam int STEP_CNT_W  = $clog2(MUL_STEPS);

    localparam logic [4:0]  COUNT_FULL = 5'(BLOCK_BYTES);

    localparam logic [63:0] R_LOW_CLAMP  = 64'h0fff_fffc_0fff_ffff;
    localparam logic [63:0] R_HIGH_CLAMP = 64'h0fff_fffc_0fff_fffc;

    // configuration register indexes
    localparam logic [1:0] CFG_R_LOW  = 2'd0;
    localparam logic [1:0] CFG_R_HIGH = 2'd1;
    localparam logic [1:0] CFG_S_LOW  = 2'd2;
    localparam logic [1:0] CFG_S_HIGH = 2'd3;

endpackage

// ----- hdl/poly1305_mac_block.sv -----
// Poly1305 one-time authenticator, bit-serial modular multiply.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------------
//  in      | sink      | in_valid / in_stall  | block_low, block_high, byte_count, last
//  out     | source    | out_valid / out_stall| tag_low, tag_high
//  cfg     | sink      | cfg_we               | cfg_index, cfg_data (r_low..s_high)
//
// A block with a nonzero byte count passes through ST_ADD, ST_MUL and ST_RED
// before the next beat can be taken; ST_MUL is the interleaved multiply,
// which consumes one bit of (acc + block) per cycle. A last beat then goes
// through ST_TAG to form the tag, waiting there while the output register
// is still full. A zero-count, non-last beat is taken and dropped at once.
// rst_n clears the key registers, the accumulator and the output valid.
// A finished tag waits in the output register; new beats are taken meanwhile.
module poly1305_mac_block
    import p1305_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // message beats
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] block_low,
    input  logic [63:0] block_high,
    input  logic [4:0]  byte_count,
    input  logic        last,
    // tag beats
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] tag_low,
    output logic [63:0] tag_high,
    // key registers
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,  // waiting for a beat
        ST_ADD  = 5'b00010,  // h = acc + block
        ST_MUL  = 5'b00100,  // prod = h * r, one bit of h per cycle
        ST_RED  = 5'b01000,  // final conditional subtract of p
        ST_TAG  = 5'b10000   // tag = acc + s, into the output register
    } state_t;

    state_t                  state_reg, state_next;

    logic [63:0]             r_low_reg, r_high_reg, s_low_reg, s_high_reg;
    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic [MSG_W-1:0]        m_reg, m_next;
    logic                    last_reg, last_next;
    logic [H_W-1:0]          h_reg, h_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [STEP_CNT_W-1:0]   step_reg, step_next;
    logic                    out_valid_reg, out_valid_next;
    logic [127:0]            tag_reg, tag_next;

    logic                    in_accept;
    logic [4:0]              count_sat;
    logic [MSG_W-1:0]        m_in;
    logic [127:0]            r_clamped;
    logic [PROD_W:0]         mac_sum;      // 2*prod + bit*r, one bit wider
    logic [PROD_W-1:0]       mac_fold;     // top two bits folded back times 5
    logic [PROD_W-1:0]       red_try;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign tag_low   = tag_reg[63:0];
    assign tag_high  = tag_reg[127:64];

    assign r_clamped = {r_high_reg & R_HIGH_CLAMP, r_low_reg & R_LOW_CLAMP};

    // Mask bytes past the count and append the 0x01 pad byte.
    assign count_sat = (byte_count > COUNT_FULL) ? COUNT_FULL : byte_count;
    always_comb
    begin
        m_in = '0;
        for (int i = 0; i < BLOCK_BYTES; i++)
        begin
            if (5'(i) < count_sat)
            begin
                m_in[8*i +: 8] = (i < 8) ? block_low[8*(i%8) +: 8]
                                         : block_high[8*(i%8) +: 8];
            end
            if (5'(i) == count_sat)
            begin
                m_in[8*i] = 1'b1;
            end
        end
        m_in[MSG_W-1] = (count_sat == COUNT_FULL);
    end

    // Interleaved multiply, MSB of h first. 2^130 = 5 mod p, so the bits
    // above 2^130 fold back as times 5; prod stays below 2^130 + 15.
    assign mac_sum  = {prod_reg, 1'b0} + (h_reg[H_W-1] ? {4'b0, r_clamped} : '0);
    assign mac_fold = {1'b0, mac_sum[ACC_W-1:0]}
                    + {{(PROD_W-4){1'b0}}, mac_sum[PROD_W:ACC_W], 2'b00}
                    + {{(PROD_W-2){1'b0}}, mac_sum[PROD_W:ACC_W]};

    // prod < 2p, so one subtract of p suffices: prod >= p iff prod + 5 >= 2^130.
    assign red_try  = prod_reg + PROD_W'(5);

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        m_next         = m_reg;
        last_next      = last_reg;
        h_next         = h_reg;
        prod_next      = prod_reg;
        step_next      = step_reg;
        tag_next       = tag_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    m_next    = m_in;
                    last_next = last;
                    if (count_sat != 5'd0)
                    begin
                        state_next = ST_ADD;
                    end
                    else if (last)
                    begin
                        state_next = ST_TAG;
                    end
                end
            end
            ST_ADD:
            begin
                h_next     = {1'b0, acc_reg} + {{(H_W-MSG_W){1'b0}}, m_reg};
                prod_next  = '0;
                step_next  = STEP_CNT_W'(MUL_STEPS - 1);
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next = mac_fold;
                h_next    = {h_reg[H_W-2:0], 1'b0};
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = ST_RED;
                end
            end
            ST_RED:
            begin
                acc_next   = red_try[ACC_W] ? red_try[ACC_W-1:0] : prod_reg[ACC_W-1:0];
                state_next = last_reg ? ST_TAG : ST_IDLE;
            end
            ST_TAG:
            begin
                // wait until the output register is free or being emptied
                if (!out_valid_reg || !out_stall)
                begin
                    tag_next       = acc_reg[127:0] + {s_high_reg, s_low_reg};
                    out_valid_next = 1'b1;
                    acc_next       = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and key state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            r_low_reg     <= '0;
            r_high_reg    <= '0;
            s_low_reg     <= '0;
            s_high_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_R_LOW:  r_low_reg  <= cfg_data;
                    CFG_R_HIGH: r_high_reg <= cfg_data;
                    CFG_S_LOW:  s_low_reg  <= cfg_data;
                    CFG_S_HIGH: s_high_reg <= cfg_data;
                    default:    r_low_reg  <= r_low_reg;
                endcase
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        last_reg <= last_next;
        h_reg    <= h_next;
        prod_reg <= prod_next;
        step_reg <= step_next;
        tag_reg  <= tag_next;
    end

endmodule

// ----- hdl/p1305_checker.sv -----
// Port-level checks for the Poly1305 MAC block, bound to poly1305_mac_block.
module p1305_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [4:0]  byte_count,
    input logic        last,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] tag_low,
    input logic [63:0] tag_high
);

    // a block with data keeps the input side busy while it is multiplied
    a_busy_after_block: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && byte_count != 5'd0) |=> in_stall)
        else $error("input taken again right after a data beat");

    // a non-last beat never produces a tag in the following cycle
    a_no_tag_without_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !last) |=> !$rose(out_valid))
        else $error("tag appeared after a non-last beat");

    // a zero-count non-last beat is dropped and the input stays open
    a_empty_beat_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && byte_count == 5'd0 && !last) |=> !in_stall)
        else $error("empty non-last beat stalled the input");

    a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_out_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(tag_low) && $stable(tag_high)))
        else $error("tag changed while stalled");

endmodule

bind poly1305_mac_block p1305_checker u_p1305_checker (.*);
